[rtl/iol_pkg.sv]
// shared types, constants and codes for the indexed ordered list
package iol_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int ACT_W    = 3;
   localparam int POS_W    = 7;
   localparam int STAT_W   = 2;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic [IDX_W-1:0]         idx_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_READ = 3'd0,
      ACT_HEAD = 3'd1,
      ACT_TAIL = 3'd2,
      ACT_AT   = 3'd3,
      ACT_DEL  = 3'd4
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [POS_W-1:0] position;
      data_type         value;
   } req_type;

   typedef struct packed {
      data_type          read_value;
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  count_now;
   } rsp_type;

   typedef struct packed {
      logic       ins;
      logic       del;
      logic       rd;
      idx_type    idx;
      status_type status;
   } op_ctrl_type;

endpackage

[rtl/iol_decode.sv]
// action decode with range and full checks against the current count
module iol_decode (
   input  logic                      valid,
   input  logic [iol_pkg::ACT_W-1:0] action,
   input  logic [iol_pkg::POS_W-1:0] position,
   input  iol_pkg::count_type        count,
   output iol_pkg::op_ctrl_type      ctrl
);
   import iol_pkg::*;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             full;

   assign pos_ext = CMP_W'(position);
   assign cnt_ext = CMP_W'(count);
   assign full    = (count == CNT_W'(CAPACITY));

   always_comb begin
      ctrl        = '0;
      ctrl.status = ST_RANGE;
      unique case (action_type'(action))
         ACT_READ: begin
            if (pos_ext < cnt_ext) begin
               ctrl.rd     = valid;
               ctrl.idx    = IDX_W'(position);
               ctrl.status = ST_DONE;
            end
         end
         ACT_HEAD: begin
            if (full) begin
               ctrl.status = ST_FULL;
            end else begin
               ctrl.ins    = valid;
               ctrl.idx    = '0;
               ctrl.status = ST_DONE;
            end
         end
         ACT_TAIL: begin
            if (full) begin
               ctrl.status = ST_FULL;
            end else begin
               ctrl.ins    = valid;
               ctrl.idx    = IDX_W'(count);
               ctrl.status = ST_DONE;
            end
         end
         ACT_AT: begin
            if (pos_ext > cnt_ext) begin
               ctrl.status = ST_RANGE;
            end else if (full) begin
               ctrl.status = ST_FULL;
            end else begin
               ctrl.ins    = valid;
               ctrl.idx    = IDX_W'(position);
               ctrl.status = ST_DONE;
            end
         end
         ACT_DEL: begin
            if (pos_ext < cnt_ext) begin
               ctrl.del    = valid;
               ctrl.idx    = IDX_W'(position);
               ctrl.status = ST_DONE;
            end
         end
         default: begin
            ctrl.status = ST_RANGE;
         end
      endcase
   end

endmodule

[rtl/iol_cell_array.sv]
// row of list cells that shift up on insert, down on delete, with a read mux
module iol_cell_array (
   input  logic                 clock,
   input  iol_pkg::op_ctrl_type ctrl,
   input  iol_pkg::data_type    value,
   output iol_pkg::data_type    rd_data
);
   import iol_pkg::*;

   data_type cells_ff [CAPACITY];
   data_type cells_in [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type prev;
      data_type next;
      logic     at_or_above;
      logic     at_idx;

      if (i == 0) begin : g_first
         assign prev = value;
      end else begin : g_prev
         assign prev = cells_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next = cells_ff[i];
      end else begin : g_next
         assign next = cells_ff[i+1];
      end

      assign at_or_above = (IDX_W'(i) >= ctrl.idx);
      assign at_idx      = (IDX_W'(i) == ctrl.idx);

      always_comb begin
         cells_in[i] = cells_ff[i];
         if (ctrl.ins && at_or_above) begin
            cells_in[i] = at_idx ? value : prev;
         end else if (ctrl.del && at_or_above) begin
            cells_in[i] = next;
         end
      end

      always_ff @(posedge clock) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   assign rd_data = cells_ff[ctrl.idx];

endmodule

[rtl/indexed_ordered_list.sv]
// top level of the indexed ordered list
// a result strobes once its request has passed the request register and then the result register
// throughput: one request per cycle, busy is never raised
// the whole action runs combinationally between the request and result registers
// synchronous reset empties the list and drops any request in flight
// results cannot be stalled by the receiver
module indexed_ordered_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  iol_pkg::req_type req_data,
   output logic             rsp_valid,
   output iol_pkg::rsp_type rsp_data
);
   import iol_pkg::*;

   logic        accept;
   logic        req_valid_ff;
   req_type     req_ff;
   count_type   count_ff;
   count_type   count_in;
   op_ctrl_type ctrl;
   data_type    rd_data;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   iol_decode u_decode (
      .valid    (req_valid_ff),
      .action   (req_ff.action),
      .position (req_ff.position),
      .count    (count_ff),
      .ctrl     (ctrl)
   );

   iol_cell_array u_cells (
      .clock   (clock),
      .ctrl    (ctrl),
      .value   (req_ff.value),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in.read_value = ctrl.rd ? rd_data : '1;
      rsp_in.status     = ctrl.status;
      rsp_in.count_now  = POS_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/iol_checker.sv]
// port-level checks for the indexed ordered list, bound to the top level
module iol_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input iol_pkg::req_type req_data,
   input logic             rsp_valid,
   input iol_pkg::rsp_type rsp_data
);
   import iol_pkg::*;

   logic req_xfer;
   assign req_xfer = start && !busy;

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (req_xfer ##1 !reset) |=> rsp_valid)
      else $error("request transfer without result two cycles later");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_xfer, 2))
      else $error("result without a request transfer two cycles earlier");

   a_value_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_DONE) |-> (rsp_data.read_value == '1))
      else $error("failed action returned a value other than minus one");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |->
         (rsp_data.count_now == POS_W'(CAPACITY)))
      else $error("full status with count below capacity");

endmodule

bind indexed_ordered_list iol_checker u_iol_checker (.*);
